/* sv/local_maximum_point_detector_assert.svh */
// Assertion macros used by the port-level checker file.
`ifndef LOCAL_MAXIMUM_POINT_DETECTOR_ASSERT_SVH
`define LOCAL_MAXIMUM_POINT_DETECTOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define LMPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked on every clock edge outside reset.
`define LMPD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* sv/lmpd_pkg.sv */
// Package with shared constants and types of the local maximum point detector.
package lmpd_pkg;
  localparam int MaxWidth  = 256;
  localparam int MaxHeight = 256;
  localparam int XW = $clog2(MaxWidth);
  localparam int YW = $clog2(MaxHeight);
  localparam int AW = XW + YW;
  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_FETCH = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_COEFF  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [7:0]         x;
    logic [7:0]         y;
    logic signed [31:0] value;
  } op_t;

  typedef struct packed {
    logic               found;
    logic [7:0]         x;
    logic [7:0]         y;
    logic signed [31:0] value;
  } res_t;
endpackage

/* sv/lmpd_front.sv */
// Front end: classifies input words, filters out-of-range loads and no-op words, queues the rest.
module lmpd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [1:0]        command,
  input  logic [7:0]        pixel_x,
  input  logic [7:0]        pixel_y,
  input  logic signed [31:0] pixel_value,
  input  logic [8:0]        eff_w,
  input  logic [8:0]        eff_h,
  output logic              full,
  output logic              q_valid,
  output lmpd_pkg::op_t     q_op,
  input  logic              q_take
);
  lmpd_pkg::op_t q_mem_r [lmpd_pkg::QDEPTH];
  logic          rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          acc, keep;
  lmpd_pkg::cmd_t c;

  assign c = lmpd_pkg::cmd_t'(command);
  assign full = (cnt_r == 2'(lmpd_pkg::QDEPTH));
  assign acc = push && !full;
  always_comb begin
    unique case (c)
      lmpd_pkg::CMD_START, lmpd_pkg::CMD_FETCH: keep = 1'b1;
      lmpd_pkg::CMD_LOAD: keep = ({1'b0, pixel_x} < eff_w) && ({1'b0, pixel_y} < eff_h);
      default: keep = 1'b0;
    endcase
  end
  assign q_valid = (cnt_r != 2'd0);
  assign q_op = q_mem_r[rd_r];
  always_comb begin
    wr_nxt = wr_r + 1'b1;
    rd_nxt = rd_r + 1'b1;
    cnt_nxt = cnt_r + ((acc && keep) ? 2'd1 : 2'd0) - ((q_take && q_valid) ? 2'd1 : 2'd0);
  end
  always_ff @(posedge clk) begin
    if (acc && keep) begin
      q_mem_r[wr_r] <= '{cmd: c, x: pixel_x, y: pixel_y, value: pixel_value};
    end
    if (!rst_n) begin
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (acc && keep) wr_r <= wr_nxt;
      if (q_take && q_valid) rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

/* sv/lmpd_back.sv */
// Back end: pixel store, min/max tracking, scan sequencer and result register.
module lmpd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  lmpd_pkg::op_t     q_op,
  output logic              q_take,
  input  logic [8:0]        eff_w,
  input  logic [8:0]        eff_h,
  input  logic [16:0]       coeff,
  output logic              res_valid,
  output lmpd_pkg::res_t    res,
  input  logic              res_pop
);
  typedef enum logic [2:0] {
    S_IDLE, S_NEXT, S_RDC, S_NB, S_CHK, S_THR
  } state_t;

  state_t state_r;
  logic signed [31:0] mem [lmpd_pkg::MaxWidth * lmpd_pkg::MaxHeight];
  logic signed [31:0] rdata_r;
  logic [lmpd_pkg::AW-1:0] raddr;
  logic signed [31:0] min_r, max_r, cval_r;
  logic any_r;
  logic [8:0] col_r;
  logic [8:0] row_r;
  logic [3:0] k_r;
  logic peak_r;
  logic signed [48:0] prod_r;
  logic signed [49:0] thr;
  logic [16:0] coeff_sat;
  logic res_valid_r;
  lmpd_pkg::res_t res_r;
  logic signed [9:0] nx, ny;
  logic nb_in;
  logic [2:0] kk;

  // Offsets of the eight neighbors, one per value of kk.
  always_comb begin
    kk = k_r[2:0];
    nx = $signed({1'b0, col_r}) + ((kk == 3'd0 || kk == 3'd3 || kk == 3'd5) ? -10'sd1 :
         (kk == 3'd2 || kk == 3'd4 || kk == 3'd7) ? 10'sd1 : 10'sd0);
    ny = $signed({1'b0, row_r}) + ((kk <= 3'd2) ? -10'sd1 : (kk >= 3'd5) ? 10'sd1 : 10'sd0);
    nb_in = (nx >= 0) && (ny >= 0) && (nx < $signed({1'b0, eff_w})) &&
            (ny < $signed({1'b0, eff_h}));
  end

  always_comb begin
    if (state_r == S_NEXT || state_r == S_IDLE) raddr = {col_r[7:0], row_r[7:0]};
    else raddr = {nx[7:0], ny[7:0]};
  end

  assign coeff_sat = coeff[16] ? 17'h10000 : coeff;
  assign thr = {{2{min_r[31]}}, min_r, 16'd0} + 50'(prod_r);
  assign q_take = (state_r == S_IDLE) && q_valid &&
                  !(res_valid_r && q_op.cmd == lmpd_pkg::CMD_FETCH);
  assign res_valid = res_valid_r;
  assign res = res_r;

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
    if (q_take && q_op.cmd == lmpd_pkg::CMD_LOAD) begin
      mem[{q_op.x, q_op.y}] <= q_op.value;
    end
    prod_r <= ($signed({max_r[31], max_r}) - $signed({min_r[31], min_r})) *
              $signed({1'b0, coeff_sat});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      min_r <= '0;
      max_r <= '0;
      any_r <= 1'b0;
      col_r <= '0;
      row_r <= '0;
      k_r <= '0;
      peak_r <= 1'b0;
      cval_r <= '0;
      res_valid_r <= 1'b0;
      res_r <= '0;
    end else begin
      if (res_valid_r && res_pop) res_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_take) begin
            unique case (q_op.cmd)
              lmpd_pkg::CMD_START: begin
                min_r <= '0;
                max_r <= '0;
                any_r <= 1'b0;
                col_r <= '0;
                row_r <= '0;
              end
              lmpd_pkg::CMD_LOAD: begin
                any_r <= 1'b1;
                if (!any_r || q_op.value < min_r) min_r <= q_op.value;
                if (!any_r || q_op.value > max_r) max_r <= q_op.value;
              end
              lmpd_pkg::CMD_FETCH: state_r <= S_NEXT;
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_NEXT: begin
          if (col_r >= eff_w) begin
            res_r <= '0;
            res_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end else if (row_r >= eff_h) begin
            col_r <= col_r + 9'd1;
            row_r <= '0;
          end else begin
            state_r <= S_RDC;
          end
        end
        S_RDC: begin
          cval_r <= rdata_r;
          peak_r <= 1'b1;
          k_r <= '0;
          state_r <= S_NB;
        end
        S_NB: begin
          // The read of neighbor k_r is in flight.
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (nb_in && cval_r < rdata_r) peak_r <= 1'b0;
          if (k_r == 4'd7) begin
            state_r <= S_THR;
          end else begin
            k_r <= k_r + 4'd1;
            state_r <= S_NB;
          end
        end
        S_THR: begin
          row_r <= row_r + 9'd1;
          if (peak_r && ($signed({cval_r[31], cval_r[31], cval_r, 16'd0}) > thr)) begin
            res_r <= '{found: 1'b1, x: col_r[7:0], y: row_r[7:0], value: cval_r};
            res_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_NEXT;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

/* sv/local_maximum_point_detector.sv */
// Top level of the local maximum point detector.
// Start and load words stream at one per cycle through the two-entry queue while
// the back end is idle, even while a result word waits to be popped; a fetch
// waits until the result register is free. A fetch walks the pixel store through
// its single read port; for each pixel examined it steps the cursor, reads the
// center, reads each of the eight neighbors in turn and then checks the threshold;
// the cursor also steps through each column change, and the scan returns a
// not-found word when it runs off the end.
module local_maximum_point_detector (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_command,
  input  logic [7:0]         in_pixel_x,
  input  logic [7:0]         in_pixel_y,
  input  logic signed [31:0] in_pixel_value,
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_found,
  output logic [7:0]         out_point_x,
  output logic [7:0]         out_point_y,
  output logic signed [31:0] out_point_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data
);
  logic [8:0] width_r, height_r, eff_w, eff_h;
  logic [16:0] coeff_r;
  logic q_valid, q_take, res_valid;
  lmpd_pkg::op_t q_op;
  lmpd_pkg::res_t res;

  assign cfg_ready = 1'b1;
  assign eff_w = (width_r == 9'd0) ? 9'd1 : (width_r > 9'(lmpd_pkg::MaxWidth)) ?
                 9'(lmpd_pkg::MaxWidth) : width_r;
  assign eff_h = (height_r == 9'd0) ? 9'd1 : (height_r > 9'(lmpd_pkg::MaxHeight)) ?
                 9'(lmpd_pkg::MaxHeight) : height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 9'd256;
      height_r <= 9'd256;
      coeff_r <= '0;
    end else if (cfg_valid) begin
      unique case (lmpd_pkg::cfg_idx_t'(cfg_index))
        lmpd_pkg::CFG_WIDTH:  width_r <= cfg_data[8:0];
        lmpd_pkg::CFG_HEIGHT: height_r <= cfg_data[8:0];
        lmpd_pkg::CFG_COEFF:  coeff_r <= cfg_data;
        default: coeff_r <= coeff_r;
      endcase
    end
  end

  lmpd_front u_front (
    .clk, .rst_n, .push(in_push), .command(in_command), .pixel_x(in_pixel_x),
    .pixel_y(in_pixel_y), .pixel_value(in_pixel_value), .eff_w, .eff_h,
    .full(in_full), .q_valid, .q_op, .q_take
  );

  lmpd_back u_back (
    .clk, .rst_n, .q_valid, .q_op, .q_take, .eff_w, .eff_h, .coeff(coeff_r),
    .res_valid, .res, .res_pop(out_pop)
  );

  assign out_empty = !res_valid;
  assign out_found = res.found;
  assign out_point_x = res.x;
  assign out_point_y = res.y;
  assign out_point_value = res.value;
endmodule

/* sv/lmpd_checker.sv */
// Port-level checker for the local maximum point detector, bound to the top level.
`include "local_maximum_point_detector_assert.svh"
module lmpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic        out_found,
  input logic [7:0]  out_point_x,
  input logic [7:0]  out_point_y,
  input logic [31:0] out_point_value
);
  `LMPD_ASSERT_IMP(a_notfound_zero, clk, rst_n, !out_empty && !out_found,
    out_point_x == 8'd0 && out_point_y == 8'd0 && out_point_value == 32'd0)
  `LMPD_ASSERT_NXT(a_hold, clk, rst_n, !out_empty && !out_pop,
    !out_empty && $stable(out_found) && $stable(out_point_value))
  `LMPD_ASSERT_NXT(a_pop_drains, clk, rst_n, !out_empty && out_pop, out_empty)
endmodule

bind local_maximum_point_detector lmpd_checker u_lmpd_checker (
  .clk, .rst_n, .out_empty, .out_pop, .out_found, .out_point_x, .out_point_y,
  .out_point_value
);

/* dv/testbench.sv */
// Testbench for the local maximum point detector: directed and random image tests.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 100000;
  localparam int DrainCycles   = 40;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  lmpd_pkg::cmd_t     in_command;
  logic [7:0]         in_pixel_x;
  logic [7:0]         in_pixel_y;
  logic signed [31:0] in_pixel_value;
  logic               out_empty;
  logic               out_pop;
  logic               out_found;
  logic [7:0]         out_point_x;
  logic [7:0]         out_point_y;
  logic signed [31:0] out_point_value;
  logic               cfg_valid;
  logic               cfg_ready;
  lmpd_pkg::cfg_idx_t cfg_index;
  logic [16:0]        cfg_data;

  local_maximum_point_detector i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_command     (in_command),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_y     (in_pixel_y),
    .in_pixel_value (in_pixel_value),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_found      (out_found),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_point_value(out_point_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  logic signed [31:0] img_mem [0:65535];
  bit                 img_written [0:65535];
  longint             run_min;
  longint             run_max;
  bit                 seen_load;
  int                 cur_col;
  int                 cur_row;
  int                 reg_width;
  int                 reg_height;
  int                 reg_coeff;
  lmpd_pkg::res_t     expected_points[$];
  bit                 last_found;

  int errors;
  int words_sent;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  bit hold_req;
  int idle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int eff_size(int r);
    if (r < 1) return 1;
    if (r > 256) return 256;
    return r;
  endfunction

  function automatic bit is_peak(int x, int y, int w, int h);
    longint c;
    c = img_mem[x * 256 + y];
    for (int dx = -1; dx <= 1; dx++) begin
      for (int dy = -1; dy <= 1; dy++) begin
        if ((dx != 0 || dy != 0) && x + dx >= 0 && y + dy >= 0 && x + dx < w &&
            y + dy < h) begin
          if (c < longint'(img_mem[(x + dx) * 256 + y + dy])) return 0;
        end
      end
    end
    return 1;
  endfunction

  task automatic predict_word(lmpd_pkg::cmd_t cmd, int x, int y, logic signed [31:0] v);
    int w;
    int h;
    longint coeff;
    longint thr;
    lmpd_pkg::res_t r;
    w = eff_size(reg_width);
    h = eff_size(reg_height);
    case (cmd)
      lmpd_pkg::CMD_START: begin
        run_min = 0;
        run_max = 0;
        seen_load = 0;
        cur_col = 0;
        cur_row = 0;
      end
      lmpd_pkg::CMD_LOAD: begin
        if (x < w && y < h) begin
          img_mem[x * 256 + y] = v;
          img_written[x * 256 + y] = 1;
          if (!seen_load) begin
            run_min = v;
            run_max = v;
            seen_load = 1;
          end else begin
            if (v < run_min) run_min = v;
            if (v > run_max) run_max = v;
          end
        end
      end
      lmpd_pkg::CMD_FETCH: begin
        coeff = (reg_coeff > 65536) ? 65536 : reg_coeff;
        thr = run_min * 65536 + (run_max - run_min) * coeff;
        r = '0;
        while (cur_col < w && !r.found) begin
          if (cur_row >= h) begin
            cur_col++;
            cur_row = 0;
          end else begin
            if (!img_written[cur_col * 256 + cur_row]) begin
              $error("fetch would read an unwritten pixel");
              errors++;
            end
            if (is_peak(cur_col, cur_row, w, h) &&
                longint'(img_mem[cur_col * 256 + cur_row]) * 65536 > thr) begin
              r.found = 1'b1;
              r.x = cur_col[7:0];
              r.y = cur_row[7:0];
              r.value = img_mem[cur_col * 256 + cur_row];
            end
            cur_row++;
          end
        end
        last_found = r.found;
        expected_points = {expected_points, r};
      end
      default: ;
    endcase
  endtask

  task automatic send_word(lmpd_pkg::cmd_t cmd, int x, int y, logic signed [31:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_push <= 1'b1;
    in_command <= cmd;
    in_pixel_x <= x[7:0];
    in_pixel_y <= y[7:0];
    in_pixel_value <= v;
    forever begin
      @(posedge clk);
      if (!in_full) break;
      @(negedge clk);
    end
    predict_word(cmd, x, y, v);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_push <= 1'b0;
    while (expected_points.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(lmpd_pkg::cfg_idx_t idx, int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[16:0];
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
      @(negedge clk);
    end
    case (idx)
      lmpd_pkg::CFG_WIDTH:  reg_width = data & 'h1FF;
      lmpd_pkg::CFG_HEIGHT: reg_height = data & 'h1FF;
      default:              reg_coeff = data & 'h1FFFF;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_image(int w, int h, int coeff);
    wait_drain();
    write_reg(lmpd_pkg::CFG_WIDTH, w);
    write_reg(lmpd_pkg::CFG_HEIGHT, h);
    write_reg(lmpd_pkg::CFG_COEFF, coeff);
  endtask

  function automatic logic signed [31:0] pick_value(int mode);
    case (mode)
      0: return $urandom_range(0, 3) - 1;
      1: return $urandom();
      default: begin
        case ($urandom_range(3))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return 0;
          default: return $urandom_range(0, 20) - 10;
        endcase
      end
    endcase
  endfunction

  task automatic load_image(int mode, bit noise);
    int w;
    int h;
    w = eff_size(reg_width);
    h = eff_size(reg_height);
    send_word(lmpd_pkg::CMD_START, $urandom_range(255), $urandom_range(255), $urandom());
    for (int x = 0; x < w; x++) begin
      for (int y = 0; y < h; y++) begin
        send_word(lmpd_pkg::CMD_LOAD, x, y, pick_value(mode));
        if (noise && $urandom_range(99) < 8) begin
          if ($urandom_range(1)) begin
            send_word(lmpd_pkg::CMD_NONE, $urandom_range(255), $urandom_range(255),
                      $urandom());
          end else begin
            send_word(lmpd_pkg::CMD_LOAD, $urandom_range(255), $urandom_range(255),
                      $urandom());
          end
        end
      end
    end
  endtask

  task automatic fetch_all();
    last_found = 1;
    while (last_found) begin
      send_word(lmpd_pkg::CMD_FETCH, $urandom_range(255), $urandom_range(255), $urandom());
    end
    send_word(lmpd_pkg::CMD_FETCH, 0, 0, 0);
  endtask

  task automatic test_directed();
    set_image(3, 3, 0);
    send_word(lmpd_pkg::CMD_START, 0, 0, 0);
    send_word(lmpd_pkg::CMD_LOAD, 0, 0, 32'sh8000_0000);
    send_word(lmpd_pkg::CMD_LOAD, 0, 1, 5);
    send_word(lmpd_pkg::CMD_LOAD, 0, 2, 5);
    send_word(lmpd_pkg::CMD_LOAD, 1, 0, 32'sh7FFF_FFFF);
    send_word(lmpd_pkg::CMD_LOAD, 1, 1, 7);
    send_word(lmpd_pkg::CMD_LOAD, 1, 2, 5);
    send_word(lmpd_pkg::CMD_LOAD, 2, 0, -1);
    send_word(lmpd_pkg::CMD_LOAD, 2, 1, 5);
    send_word(lmpd_pkg::CMD_LOAD, 2, 2, 5);
    send_word(lmpd_pkg::CMD_LOAD, 255, 255, 32'sh7FFF_FFFF);
    send_word(lmpd_pkg::CMD_NONE, 255, 255, 32'shFFFF_FFFF);
    fetch_all();
    send_word(lmpd_pkg::CMD_START, 0, 0, 0);
    fetch_all();
    set_image(3, 3, 131071);
    send_word(lmpd_pkg::CMD_START, 0, 0, 0);
    send_word(lmpd_pkg::CMD_LOAD, 1, 1, 9);
    fetch_all();
  endtask

  task automatic test_size_extremes();
    set_image(511, 0, 65536);
    load_image(2, 0);
    fetch_all();
    set_image(0, 511, 32768);
    load_image(1, 0);
    fetch_all();
  endtask

  task automatic test_size_change_mid_scan();
    set_image(5, 6, 0);
    load_image(0, 0);
    send_word(lmpd_pkg::CMD_FETCH, 0, 0, 0);
    send_word(lmpd_pkg::CMD_FETCH, 0, 0, 0);
    set_image(4, 2, 0);
    fetch_all();
  endtask

  task automatic test_backpressure();
    set_image(4, 4, 0);
    load_image(0, 0);
    hold_req = 1;
    for (int i = 0; i < 10; i++) send_word(lmpd_pkg::CMD_FETCH, 0, 0, 0);
    wait_drain();
  endtask

  task automatic test_random_images(int n_words);
    int stop_at;
    int w;
    int h;
    int c;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 6);
      if ($urandom_range(99) < 4) w = 30;
      case ($urandom_range(3))
        0: c = 0;
        1: c = 65536;
        2: c = $urandom_range(65536, 131071);
        default: c = $urandom_range(0, 65535);
      endcase
      set_image(w, h, c);
      load_image($urandom_range(2), 1);
      if ($urandom_range(99) < 80) begin
        fetch_all();
      end else begin
        repeat ($urandom_range(1, 3)) send_word(lmpd_pkg::CMD_FETCH, 0, 0, 0);
        wait_drain();
        write_reg(lmpd_pkg::CFG_COEFF, $urandom_range(0, 131071));
        fetch_all();
      end
    end
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_req) begin
      hold_req = 0;
      hold_left = 300;
      out_pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    lmpd_pkg::res_t e;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_points.size() == 0) begin
        $error("result word with none expected");
        errors++;
      end else begin
        e = expected_points.pop_front();
        if (out_found !== e.found) begin
          $error("found: expected %0d, actual %0d", e.found, out_found);
          errors++;
        end
        if (out_point_x !== e.x) begin
          $error("point_x: expected %0d, actual %0d", e.x, out_point_x);
          errors++;
        end
        if (out_point_y !== e.y) begin
          $error("point_y: expected %0d, actual %0d", e.y, out_point_y);
          errors++;
        end
        if (out_point_value !== e.value) begin
          $error("point_value: expected %0d, actual %0d", e.value, out_point_value);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
        (cfg_valid && cfg_ready)) begin
      idle_count <= 0;
    end else if (idle_count >= WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    errors = 0;
    words_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    hold_req = 0;
    idle_count = 0;
    run_min = 0;
    run_max = 0;
    seen_load = 0;
    cur_col = 0;
    cur_row = 0;
    reg_width = 256;
    reg_height = 256;
    reg_coeff = 0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_command = lmpd_pkg::CMD_START;
    in_pixel_x = '0;
    in_pixel_y = '0;
    in_pixel_value = '0;
    cfg_valid = 1'b0;
    cfg_index = lmpd_pkg::CFG_WIDTH;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_size_extremes();
    test_size_change_mid_scan();
    test_backpressure();
    test_random_images(60);
    send_idle_pct = 52;
    test_random_images(60);
    send_idle_pct = 0;
    recv_stall_pct = 52;
    test_random_images(60);
    send_idle_pct = 35;
    recv_stall_pct = 35;
    test_backpressure();
    test_random_images(60);
    wait_drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

/* local_maximum_point_detector.f */
+incdir+sv
sv/lmpd_pkg.sv
sv/lmpd_front.sv
sv/lmpd_back.sv
sv/local_maximum_point_detector.sv
sv/lmpd_checker.sv
dv/testbench.sv
